FILE: rtl/core/c2p_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package c2p_pkg;

    // Coordinate width is fixed by the payload fields.
    localparam int COORD_WIDTH = 16;

    // Square root: one result bit per step.
    localparam int SQRT_STEPS = COORD_WIDTH;
    localparam int SQ_W       = 2 * COORD_WIDTH;
    localparam int SQ_T_W     = 2 * COORD_WIDTH + 2;

    // CORDIC vector components carry FRAC_BITS fraction bits.
    localparam int FRAC_BITS = 60 - COORD_WIDTH;
    localparam int XY_W      = 63;

    // Angles in 1/65536 degree; a full turn needs 25 bits.
    localparam int ANG_W    = 25;
    localparam int ATAN_LEN = 24;

    localparam logic [ANG_W-1:0] DEG_90  = ANG_W'(90 * 65536);
    localparam logic [ANG_W-1:0] DEG_180 = ANG_W'(180 * 65536);
    localparam logic [ANG_W-1:0] DEG_270 = ANG_W'(270 * 65536);
    localparam logic [ANG_W-1:0] DEG_360 = ANG_W'(360 * 65536);

    // Output angle is rounded to 1/128 degree.
    localparam logic [ANG_W-1:0] ROUND_HALF    = ANG_W'(256);
    localparam int               ANGLE_SHIFT   = 9;
    localparam int               OUT_ANG_W     = 16;
    localparam logic [15:0]      FULL_TURN_OUT = 16'd46080;

    localparam logic [2:0] QUAD_I   = 3'd1;
    localparam logic [2:0] QUAD_II  = 3'd2;
    localparam logic [2:0] QUAD_III = 3'd3;
    localparam logic [2:0] QUAD_IV  = 3'd4;

    typedef struct packed {
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
    } point_t;

    typedef struct packed {
        logic [2:0]  quadrant;
        logic [15:0] radius;
        logic [15:0] angle_deg;
        logic        at_origin;
    } result_t;

    // Per-point flags that ride along the pipeline.
    typedef struct packed {
        logic [2:0] quad;
        logic       origin;
        logic       x_zero;
        logic       y_zero;
        logic       x_neg;
        logic       y_neg;
    } side_t;

    // atan(2^-i) in degrees, scaled by 65536 and rounded.
    function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
        logic signed [ANG_W-1:0] val;
        begin
            case (idx)
                0:       val = ANG_W'(2949120);
                1:       val = ANG_W'(1740967);
                2:       val = ANG_W'(919879);
                3:       val = ANG_W'(466945);
                4:       val = ANG_W'(234379);
                5:       val = ANG_W'(117304);
                6:       val = ANG_W'(58666);
                7:       val = ANG_W'(29335);
                8:       val = ANG_W'(14668);
                9:       val = ANG_W'(7334);
                10:      val = ANG_W'(3667);
                11:      val = ANG_W'(1833);
                12:      val = ANG_W'(917);
                13:      val = ANG_W'(458);
                14:      val = ANG_W'(229);
                15:      val = ANG_W'(115);
                16:      val = ANG_W'(57);
                17:      val = ANG_W'(29);
                18:      val = ANG_W'(14);
                19:      val = ANG_W'(7);
                20:      val = ANG_W'(4);
                21:      val = ANG_W'(2);
                22:      val = ANG_W'(1);
                default: val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cartesian_to_polar_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Cartesian to polar conversion of one signed point per transaction.
// Input channel: point is taken at a rising edge where start is high and busy
// is low. busy is always low, so a new point can be started in every cycle.
// Output channel: result is valid for exactly one cycle while done is high and
// is taken at the edge that ends that cycle; there is no backpressure.
// Radius comes from a pipelined restoring square root (one bit per stage) of
// x*x + y*y with round-to-nearest; the angle comes from a CORDIC vectoring
// pipeline (one rotation per stage) on |x|, |y|, then a quadrant fold and
// rounding to 1/128 degree.
// Throughput is one transaction per cycle. The pipeline depth is set by the
// longer of the CORDIC chain and the 16 square root steps, plus abs, square,
// sum and three output stages.
// Reset clears every valid bit, so no result emerges from points that were in
// flight; the data registers are not reset.
module cartesian_to_polar_core #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire c2p_pkg::point_t   point,
    output logic                   done,
    output c2p_pkg::result_t       result
);

    localparam int CW    = c2p_pkg::COORD_WIDTH;
    localparam int XY_W  = c2p_pkg::XY_W;
    localparam int ANG_W = c2p_pkg::ANG_W;
    localparam int SQ_W  = c2p_pkg::SQ_W;
    localparam int SQ_T_W = c2p_pkg::SQ_T_W;
    localparam int SQRT_STEPS = c2p_pkg::SQRT_STEPS;
    localparam int DEPTH = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
    localparam int LATENCY = DEPTH + 6;

    // ------------------------------------------------------------------
    // Stage A: magnitudes and flags.
    // ------------------------------------------------------------------
    logic                  a_valid_reg;
    logic [CW-1:0]         a_ax_reg;
    logic [CW-1:0]         a_ay_reg;
    c2p_pkg::side_t        a_side_reg;
    logic [CW-1:0]         a_ax_next;
    logic [CW-1:0]         a_ay_next;
    c2p_pkg::side_t        a_side_next;

    assign busy = 1'b0;

    always_comb
    begin
        // For the most negative input the 16-bit pattern of the magnitude is exact.
        a_ax_next = point.x_coord[CW-1] ? (~point.x_coord + CW'(1)) : point.x_coord;
        a_ay_next = point.y_coord[CW-1] ? (~point.y_coord + CW'(1)) : point.y_coord;
        a_side_next.x_neg  = point.x_coord[CW-1];
        a_side_next.y_neg  = point.y_coord[CW-1];
        a_side_next.x_zero = (point.x_coord == '0);
        a_side_next.y_zero = (point.y_coord == '0);
        a_side_next.origin = (point.x_coord == '0) && (point.y_coord == '0);
        if (!point.x_coord[CW-1])
        begin
            a_side_next.quad = point.y_coord[CW-1] ? c2p_pkg::QUAD_IV : c2p_pkg::QUAD_I;
        end
        else
        begin
            a_side_next.quad = point.y_coord[CW-1] ? c2p_pkg::QUAD_III : c2p_pkg::QUAD_II;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: squares.
    // ------------------------------------------------------------------
    logic                  b_valid_reg;
    logic [CW-1:0]         b_ax_reg;
    logic [CW-1:0]         b_ay_reg;
    logic [SQ_W-1:0]       b_sqx_reg;
    logic [SQ_W-1:0]       b_sqy_reg;
    c2p_pkg::side_t        b_side_reg;

    // ------------------------------------------------------------------
    // Iteration stages: index 0 is loaded by stage C, index k+1 by step k.
    // ------------------------------------------------------------------
    logic                     it_valid_reg [DEPTH+1];
    c2p_pkg::side_t           it_side_reg  [DEPTH+1];
    logic signed [XY_W-1:0]   cx_reg       [DEPTH+1];
    logic signed [XY_W-1:0]   cy_reg       [DEPTH+1];
    logic signed [ANG_W-1:0]  cz_reg       [DEPTH+1];
    logic [SQ_W-1:0]          sq_r_reg     [DEPTH+1];
    logic [CW-1:0]            sq_q_reg     [DEPTH+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
            it_valid_reg[0] <= 1'b0;
        end
        else
        begin
            a_valid_reg     <= start && !busy;
            b_valid_reg     <= a_valid_reg;
            it_valid_reg[0] <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_ax_reg    <= a_ax_next;
        a_ay_reg    <= a_ay_next;
        a_side_reg  <= a_side_next;

        b_ax_reg    <= a_ax_reg;
        b_ay_reg    <= a_ay_reg;
        b_sqx_reg   <= SQ_W'(a_ax_reg * a_ax_reg);
        b_sqy_reg   <= SQ_W'(a_ay_reg * a_ay_reg);
        b_side_reg  <= a_side_reg;

        it_side_reg[0] <= b_side_reg;
        cx_reg[0]      <= XY_W'(b_ax_reg) << c2p_pkg::FRAC_BITS;
        cy_reg[0]      <= XY_W'(b_ay_reg) << c2p_pkg::FRAC_BITS;
        cz_reg[0]      <= '0;
        sq_r_reg[0]    <= b_sqx_reg + b_sqy_reg;
        sq_q_reg[0]    <= '0;
    end

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_iter
        logic signed [XY_W-1:0]  cx_next;
        logic signed [XY_W-1:0]  cy_next;
        logic signed [ANG_W-1:0] cz_next;
        logic [SQ_W-1:0]         sq_r_next;
        logic [CW-1:0]           sq_q_next;

        if (k < CORDIC_STAGES)
        begin : g_rot
            localparam logic [XY_W-1:0] LOW_MASK = (XY_W'(1) << k) - XY_W'(1);
            localparam logic signed [ANG_W-1:0] ATAN_K = c2p_pkg::atan_entry(k);
            logic signed [XY_W-1:0] ysh;
            logic signed [XY_W-1:0] xsh;
            logic                   ytrim;

            always_comb
            begin
                ysh   = cy_reg[k] >>> k;
                xsh   = cx_reg[k] >>> k;
                ytrim = (cy_reg[k] & LOW_MASK) != '0;
                if (!cy_reg[k][XY_W-1])
                begin
                    cx_next = cx_reg[k] + ysh;
                    cy_next = cy_reg[k] - xsh;
                    cz_next = cz_reg[k] + ATAN_K;
                end
                else
                begin
                    // Shift of negative y truncates toward zero: floor plus one
                    // when bits are lost, folded into the carry of the subtract.
                    cx_next = cx_reg[k] + ~ysh + {{(XY_W-1){1'b0}}, ~ytrim};
                    cy_next = cy_reg[k] + xsh;
                    cz_next = cz_reg[k] - ATAN_K;
                end
            end
        end
        else
        begin : g_rot_pass
            always_comb
            begin
                cx_next = cx_reg[k];
                cy_next = cy_reg[k];
                cz_next = cz_reg[k];
            end
        end

        if (k < SQRT_STEPS)
        begin : g_root
            localparam int J = SQRT_STEPS - 1 - k;
            logic [SQ_T_W-1:0] trial;
            logic              fits;

            // Setting root bit J adds 2*q*2^J + 2^(2J) to the square.
            always_comb
            begin
                trial = (SQ_T_W'(sq_q_reg[k]) << (J + 1)) | (SQ_T_W'(1) << (2 * J));
                fits  = SQ_T_W'(sq_r_reg[k]) >= trial;
                if (fits)
                begin
                    sq_r_next = sq_r_reg[k] - SQ_W'(trial);
                    sq_q_next = sq_q_reg[k] | (CW'(1) << J);
                end
                else
                begin
                    sq_r_next = sq_r_reg[k];
                    sq_q_next = sq_q_reg[k];
                end
            end
        end
        else
        begin : g_root_pass
            always_comb
            begin
                sq_r_next = sq_r_reg[k];
                sq_q_next = sq_q_reg[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                it_valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                it_valid_reg[k+1] <= it_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            it_side_reg[k+1] <= it_side_reg[k];
            cx_reg[k+1]      <= cx_next;
            cy_reg[k+1]      <= cy_next;
            cz_reg[k+1]      <= cz_next;
            sq_r_reg[k+1]    <= sq_r_next;
            sq_q_reg[k+1]    <= sq_q_next;
        end
    end

    // ------------------------------------------------------------------
    // F1: clamp the first-quadrant angle, round the root.
    // ------------------------------------------------------------------
    logic               f1_valid_reg;
    logic [ANG_W-1:0]   f1_z_reg;
    logic [CW-1:0]      f1_rad_reg;
    c2p_pkg::side_t     f1_side_reg;
    logic [ANG_W-1:0]   f1_z_next;
    logic [CW-1:0]      f1_rad_next;

    always_comb
    begin
        if (cz_reg[DEPTH][ANG_W-1])
        begin
            f1_z_next = '0;
        end
        else if (cz_reg[DEPTH] > $signed(c2p_pkg::DEG_90))
        begin
            f1_z_next = c2p_pkg::DEG_90;
        end
        else
        begin
            f1_z_next = cz_reg[DEPTH];
        end
        // The remainder is s - q*q; it exceeds q exactly when sqrt(s) > q + 1/2.
        f1_rad_next = sq_q_reg[DEPTH] + CW'(sq_r_reg[DEPTH] > SQ_W'(sq_q_reg[DEPTH]));
    end

    // ------------------------------------------------------------------
    // F2: map to the full circle, axes handled exactly.
    // ------------------------------------------------------------------
    logic               f2_valid_reg;
    logic [ANG_W-1:0]   f2_a_reg;
    logic [CW-1:0]      f2_rad_reg;
    c2p_pkg::side_t     f2_side_reg;
    logic [ANG_W-1:0]   f2_a_next;

    always_comb
    begin
        if (f1_side_reg.origin)
        begin
            f2_a_next = '0;
        end
        else if (f1_side_reg.y_zero)
        begin
            f2_a_next = f1_side_reg.x_neg ? c2p_pkg::DEG_180 : '0;
        end
        else if (f1_side_reg.x_zero)
        begin
            f2_a_next = f1_side_reg.y_neg ? c2p_pkg::DEG_270 : c2p_pkg::DEG_90;
        end
        else
        begin
            case (f1_side_reg.quad)
                c2p_pkg::QUAD_I:   f2_a_next = f1_z_reg;
                c2p_pkg::QUAD_II:  f2_a_next = c2p_pkg::DEG_180 - f1_z_reg;
                c2p_pkg::QUAD_III: f2_a_next = c2p_pkg::DEG_180 + f1_z_reg;
                c2p_pkg::QUAD_IV:  f2_a_next = c2p_pkg::DEG_360 - f1_z_reg;
                default:           f2_a_next = '0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // F3: round to 1/128 degree into the output register.
    // ------------------------------------------------------------------
    logic                   done_reg;
    c2p_pkg::result_t       result_reg;
    c2p_pkg::result_t       result_next;
    logic [ANG_W-1:0]       ang_sum;
    logic [c2p_pkg::OUT_ANG_W-1:0] ang_round;

    always_comb
    begin
        ang_sum   = f2_a_reg + c2p_pkg::ROUND_HALF;
        ang_round = ang_sum[c2p_pkg::ANGLE_SHIFT +: c2p_pkg::OUT_ANG_W];
        result_next.quadrant  = f2_side_reg.quad;
        result_next.radius    = f2_rad_reg;
        result_next.angle_deg = (ang_round >= c2p_pkg::FULL_TURN_OUT) ? '0 : ang_round;
        result_next.at_origin = f2_side_reg.origin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= it_valid_reg[DEPTH];
            f2_valid_reg <= f1_valid_reg;
            done_reg     <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f1_z_reg    <= f1_z_next;
        f1_rad_reg  <= f1_rad_next;
        f1_side_reg <= it_side_reg[DEPTH];
        f2_a_reg    <= f2_a_next;
        f2_rad_reg  <= f1_rad_reg;
        f2_side_reg <= f1_side_reg;
        result_reg  <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted transaction did not produce a result");

    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without a matching transaction");

    a_origin_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.at_origin) |->
            (result.radius == '0 && result.angle_deg == '0 &&
             result.quadrant == c2p_pkg::QUAD_I))
        else $error("origin result carries nonzero radius or angle");

    a_zero_radius: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.radius == '0) |-> result.at_origin)
        else $error("zero radius away from the origin");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.angle_deg < c2p_pkg::FULL_TURN_OUT))
        else $error("angle outside a full turn");

endmodule

`default_nettype wire

FILE: bench/c2p_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the converter, predicts every result from the
// accepted point and compares the results in order, field by field.
module c2p_checker #(
    parameter int STAGES = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire c2p_pkg::point_t   point,
    input  wire logic              done,
    input  wire c2p_pkg::result_t  result,
    output int                     fail_count,
    output int                     pending
);

    localparam longint ONE_DEG   = 65536;
    localparam int     FRAC      = 60 - 16;
    localparam int     TAB_LEN   = 24;

    // atan(2^-i) in degrees, scaled by 2^16 and rounded to nearest.
    localparam longint ATAN_SCALED [TAB_LEN] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct {
        c2p_pkg::point_t  pt;
        c2p_pkg::result_t res;
    } conversion_t;

    conversion_t expected_results[$];

    task automatic report(input string msg);
        fail_count++;
        $display("%0t ns: %s", $realtime, msg);
    endtask

    // Arithmetic shift that rounds toward zero, as the vector stages do.
    function automatic longint trunc_shift(input longint v, input int s);
        if (v >= 0)
            return v >>> s;
        return -((-v) >>> s);
    endfunction

    function automatic c2p_pkg::result_t predict_polar(input c2p_pkg::point_t p);
        c2p_pkg::result_t r;
        longint  x;
        longint  y;
        longint  ax;
        longint  ay;
        longint  sq;
        longint  root;
        longint  vx;
        longint  vy;
        longint  dx;
        longint  dy;
        longint  z;
        longint  a;
        longint  ang;
        logic    origin;
        x = longint'($signed(p.x_coord));
        y = longint'($signed(p.y_coord));
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        origin = (x == 0) && (y == 0);

        if (x >= 0)
            r.quadrant = (y >= 0) ? c2p_pkg::QUAD_I : c2p_pkg::QUAD_IV;
        else
            r.quadrant = (y >= 0) ? c2p_pkg::QUAD_II : c2p_pkg::QUAD_III;

        // Radius rounded to nearest: bump when sq > root^2 + root.
        sq = ax * ax + ay * ay;
        root = longint'($sqrt(real'(sq)));
        while (root * root > sq)
            root--;
        while ((root + 1) * (root + 1) <= sq)
            root++;
        if (sq - root * root > root)
            root++;

        if (origin)
        begin
            a = 0;
        end
        else if (y == 0)
        begin
            a = (x > 0) ? 0 : 180 * ONE_DEG;
        end
        else if (x == 0)
        begin
            a = (y > 0) ? 90 * ONE_DEG : 270 * ONE_DEG;
        end
        else
        begin
            vx = ax <<< FRAC;
            vy = ay <<< FRAC;
            z  = 0;
            for (int i = 0; i < STAGES && i < TAB_LEN; i++)
            begin
                dx = trunc_shift(vy, i);
                dy = trunc_shift(vx, i);
                if (vy >= 0)
                begin
                    vx += dx;
                    vy -= dy;
                    z  += ATAN_SCALED[i];
                end
                else
                begin
                    vx -= dx;
                    vy += dy;
                    z  -= ATAN_SCALED[i];
                end
            end
            if (z < 0)
                z = 0;
            if (z > 90 * ONE_DEG)
                z = 90 * ONE_DEG;
            case (r.quadrant)
                c2p_pkg::QUAD_I:   a = z;
                c2p_pkg::QUAD_II:  a = 180 * ONE_DEG - z;
                c2p_pkg::QUAD_III: a = 180 * ONE_DEG + z;
                default:           a = 360 * ONE_DEG - z;
            endcase
        end

        // Round to 1/128 degree; a value that rounds up to a full turn wraps.
        ang = (a + 256) >>> 9;
        if (ang >= longint'(c2p_pkg::FULL_TURN_OUT))
            ang = 0;

        r.radius    = 16'(root);
        r.angle_deg = 16'(ang);
        r.at_origin = origin;
        return r;
    endfunction

    always @(posedge clk)
    begin
        conversion_t head;
        string       where;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    report($sformatf(
                        "unexpected transaction: quadrant %0d radius %0d angle %0d",
                        result.quadrant, result.radius, result.angle_deg));
                end
                else
                begin
                    head = expected_results.pop_front();
                    where = $sformatf("point (%0d,%0d)", $signed(head.pt.x_coord),
                        $signed(head.pt.y_coord));
                    if (result.quadrant !== head.res.quadrant)
                        report($sformatf("%s quadrant: got %0d, expected %0d", where,
                            result.quadrant, head.res.quadrant));
                    if (result.radius !== head.res.radius)
                        report($sformatf("%s radius: got %0d, expected %0d", where,
                            result.radius, head.res.radius));
                    if (result.angle_deg !== head.res.angle_deg)
                        report($sformatf("%s angle_deg: got %0d, expected %0d", where,
                            result.angle_deg, head.res.angle_deg));
                    if (result.at_origin !== head.res.at_origin)
                        report($sformatf("%s at_origin: got %0b, expected %0b", where,
                            result.at_origin, head.res.at_origin));
                end
            end
            if (start && !busy)
            begin
                head.pt  = point;
                head.res = predict_polar(point);
                expected_results.push_back(head);
            end
            pending = expected_results.size();
        end
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CORDIC_STAGES  = 16;
    localparam int ITEMS_PER_PASS = 445;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    c2p_pkg::point_t  point;
    logic             done;
    c2p_pkg::result_t result;
    int               fail_count;
    int               pending;

    cartesian_to_polar_core #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .point (point),
        .done  (done),
        .result(result)
    );

    c2p_checker #(
        .STAGES(CORDIC_STAGES)
    ) i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .point     (point),
        .done      (done),
        .result    (result),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic c2p_pkg::point_t make_point(input int x, input int y);
        c2p_pkg::point_t p;
        p.x_coord = 16'(x);
        p.y_coord = 16'(y);
        return p;
    endfunction

    function automatic int pick_extreme();
        int choice;
        choice = $urandom_range(5);
        case (choice)
            0:       return -32768;
            1:       return -32767;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            default: return 32767;
        endcase
    endfunction

    // Mostly full-range points, with extra weight on the axes, the corners,
    // tiny vectors, near-diagonal and near-axis points.
    function automatic c2p_pkg::point_t random_point();
        int kind;
        int mag;
        int x;
        int y;
        kind = $urandom_range(9);
        x = int'($signed(16'($urandom)));
        y = int'($signed(16'($urandom)));
        case (kind)
            4:
            begin
                x = int'($urandom_range(6)) - 3;
                y = int'($urandom_range(6)) - 3;
            end
            5:
            begin
                if ($urandom_range(1))
                    x = 0;
                else
                    y = 0;
            end
            6:
            begin
                mag = $urandom_range(32760);
                x = $urandom_range(1) ? mag : -mag;
                mag = mag + int'($urandom_range(6)) - 3;
                y = $urandom_range(1) ? mag : -mag;
            end
            7:
            begin
                x = pick_extreme();
                y = pick_extreme();
            end
            8:
            begin
                mag = int'($urandom_range(1, 3));
                if ($urandom_range(1))
                    x = $urandom_range(1) ? mag : -mag;
                else
                    y = $urandom_range(1) ? mag : -mag;
            end
            default: ;
        endcase
        return make_point(x, y);
    endfunction

    // Offers one transaction, after a random gap when the sender is idling.
    task automatic send_point(input c2p_pkg::point_t p, input int idle_pct);
        if (int'($urandom_range(99)) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        point <= p;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    initial
    begin
        int idle_pct [3];
        idle_pct = '{15, 62, 0};
        rst_n = 1'b0;
        start = 1'b0;
        point = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Origin, the four half axes, the corners and the quadrant borders.
        send_point(make_point(0, 0), 0);
        send_point(make_point(1, 0), 0);
        send_point(make_point(-1, 0), 0);
        send_point(make_point(0, 1), 0);
        send_point(make_point(0, -1), 0);
        send_point(make_point(32767, 0), 0);
        send_point(make_point(-32768, 0), 0);
        send_point(make_point(0, 32767), 0);
        send_point(make_point(0, -32768), 0);
        send_point(make_point(32767, 32767), 0);
        send_point(make_point(-32768, -32768), 0);
        send_point(make_point(-32768, 32767), 0);
        send_point(make_point(32767, -32768), 0);
        send_point(make_point(1, 1), 0);
        send_point(make_point(-1, 1), 0);
        send_point(make_point(-1, -1), 0);
        send_point(make_point(1, -1), 0);
        // Just below the positive x axis the angle rounds up to a full turn.
        send_point(make_point(32767, -1), 0);
        send_point(make_point(32767, 1), 0);
        send_point(make_point(1, 32767), 0);
        send_point(make_point(-32768, -1), 0);
        send_point(make_point(-1, -32768), 0);
        send_point(make_point(3, 4), 0);
        send_point(make_point(-12345, 23456), 0);
        drain_results();

        foreach (idle_pct[pass])
        begin
            repeat (ITEMS_PER_PASS)
                send_point(random_point(), idle_pct[pass]);
            drain_results();
        end

        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("PASS cartesian_to_polar_core");
        else
            $display("FAIL cartesian_to_polar_core");
        $finish;
    end

    initial
    begin
        #500000;
        $display("FAIL cartesian_to_polar_core");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/c2p_pkg.sv
rtl/core/cartesian_to_polar_core.sv
bench/c2p_checker.sv
bench/tb_top.sv
